// ===== design/tbps_pkg.sv =====
// tbps_pkg: types, constants and helpers for the tape byte pulse serializer
// no dependencies; used by tbps_step and tape_byte_pulse_serializer_unit
package tbps_pkg;

    localparam int OFFSET_BITS  = 17;
    localparam int LEN_BITS     = 17;
    localparam int PULSE_BITS   = 16;
    localparam int SLOT_BITS    = 4;
    localparam int REPEAT_BITS  = 7;
    localparam int CYCLE_BITS   = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [7:0]             SYNC_BYTE     = 8'h16;
    localparam logic [REPEAT_BITS-1:0] SYNC_REPEATS  = 7'd80;
    localparam logic [PULSE_BITS-1:0]  REWIND_COUNT  = 16'd2;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX    = {OFFSET_BITS{1'b1}};

    // frame slots
    localparam logic [SLOT_BITS-1:0] SLOT_START      = 4'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_SYNC       = 4'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_DATA_FIRST = 4'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_DATA_LAST  = 4'd9;
    localparam logic [SLOT_BITS-1:0] SLOT_PARITY     = 4'd10;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TAPE_LENGTH = 2'd0,
        CFG_ONE_PULSE   = 2'd1,
        CFG_ZERO_PULSE  = 2'd2
    } cfg_index_t;

    localparam logic [PULSE_BITS-1:0] ONE_PULSE_RESET  = 16'd208;
    localparam logic [PULSE_BITS-1:0] ZERO_PULSE_RESET = 16'd416;

    typedef struct packed {
        logic [CYCLE_BITS-1:0] elapsed_cycles;
        logic                  motor;
        logic                  rewind;
        logic [7:0]            tape_byte;
    } in_beat_t;

    typedef struct packed {
        logic                   tape_signal;
        logic                   edge_res;
        logic [OFFSET_BITS-1:0] next_offset;
        logic                   tape_ended;
    } out_beat_t;

    typedef struct packed {
        logic [LEN_BITS-1:0]   tape_length;
        logic [PULSE_BITS-1:0] one_pulse_cycles;
        logic [PULSE_BITS-1:0] zero_pulse_cycles;
    } cfg_t;

    typedef struct packed {
        logic                   motor_on;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [SLOT_BITS-1:0]   frame_slot;
        logic [REPEAT_BITS-1:0] repeat_left;
        logic                   parity_bit;
        logic                   signal_level;
        logic [PULSE_BITS-1:0]  pulse_length;
        logic [PULSE_BITS-1:0]  countdown;
        logic                   ended_flag;
    } play_state_t;

    localparam play_state_t STATE_RESET = '{
        motor_on:     1'b0,
        byte_offset:  '0,
        frame_slot:   '0,
        repeat_left:  SYNC_REPEATS,
        parity_bit:   1'b0,
        signal_level: 1'b0,
        pulse_length: '0,
        countdown:    REWIND_COUNT,
        ended_flag:   1'b0
    };

    localparam cfg_t CFG_RESET = '{
        tape_length:       '0,
        one_pulse_cycles:  ONE_PULSE_RESET,
        zero_pulse_cycles: ZERO_PULSE_RESET
    };

    // saturating offset advance
    function automatic logic [OFFSET_BITS-1:0] bump_offset(input logic [OFFSET_BITS-1:0] off);
        logic [OFFSET_BITS-1:0] res;
        res = (off == OFFSET_MAX) ? off : off + 1'b1;
        return res;
    endfunction

endpackage

// ===== design/tbps_step.sv =====
// tbps_step: next playback state and result for one tick beat
// depends on tbps_pkg
module tbps_step (
    input  tbps_pkg::play_state_t cur,
    input  tbps_pkg::cfg_t        cfg,
    input  tbps_pkg::in_beat_t    item,
    output tbps_pkg::play_state_t nxt,
    output tbps_pkg::out_beat_t   result
);

    tbps_pkg::play_state_t n;
    logic                  toggled;
    logic                  stop;
    logic                  past_end;
    logic [2:0]            bit_sel;
    logic [tbps_pkg::SLOT_BITS-1:0] slot_dist;

    always_comb
    begin
        n        = cur;
        toggled  = 1'b0;
        stop     = 1'b0;
        past_end = 1'b0;
        slot_dist = '0;
        bit_sel  = '0;

        if (item.rewind)
        begin
            n.byte_offset  = '0;
            n.frame_slot   = '0;
            n.countdown    = tbps_pkg::REWIND_COUNT;
            n.signal_level = 1'b0;
            n.repeat_left  = tbps_pkg::SYNC_REPEATS;
            n.ended_flag   = 1'b0;
        end

        // motor transitions
        if (item.motor != n.motor_on)
        begin
            if (!item.motor)
            begin
                if (n.frame_slot != '0)
                    n.byte_offset = tbps_pkg::bump_offset(n.byte_offset);
                n.frame_slot = '0;
            end
            else if ((n.byte_offset < cfg.tape_length) && (item.tape_byte == tbps_pkg::SYNC_BYTE))
            begin
                n.repeat_left = tbps_pkg::SYNC_REPEATS;
            end
            n.motor_on = item.motor;
        end

        past_end  = (n.byte_offset >= cfg.tape_length);
        slot_dist = n.frame_slot - tbps_pkg::SLOT_DATA_FIRST;
        bit_sel   = slot_dist[2:0];

        if (n.motor_on && (cfg.tape_length != '0) && !n.ended_flag)
        begin
            if (n.countdown > {8'd0, item.elapsed_cycles})
            begin
                n.countdown = n.countdown - {8'd0, item.elapsed_cycles};
            end
            else
            begin
                toggled = 1'b1;
                n.signal_level = ~n.signal_level;
                if (n.signal_level)
                begin
                    // pick the pulse for this frame cell
                    case (n.frame_slot) inside
                        tbps_pkg::SLOT_START:
                            n.pulse_length = cfg.one_pulse_cycles;
                        tbps_pkg::SLOT_SYNC:
                        begin
                            n.pulse_length = cfg.zero_pulse_cycles;
                            n.parity_bit   = 1'b1;
                        end
                        [tbps_pkg::SLOT_DATA_FIRST:tbps_pkg::SLOT_DATA_LAST]:
                        begin
                            if (past_end)
                                n.pulse_length = cfg.zero_pulse_cycles;
                            else if (item.tape_byte[bit_sel])
                            begin
                                n.pulse_length = cfg.one_pulse_cycles;
                                n.parity_bit   = ~n.parity_bit;
                            end
                            else
                                n.pulse_length = cfg.zero_pulse_cycles;
                        end
                        tbps_pkg::SLOT_PARITY:
                            n.pulse_length = n.parity_bit ? cfg.one_pulse_cycles
                                                          : cfg.zero_pulse_cycles;
                        default:
                            n.pulse_length = cfg.one_pulse_cycles;
                    endcase
                    n.frame_slot = n.frame_slot + 1'b1;
                    // frame wrap: end of tape, sync repeat or next byte
                    if (n.frame_slot == '0)
                    begin
                        if (past_end)
                        begin
                            n.ended_flag = 1'b1;
                            stop = 1'b1;
                        end
                        else if (n.repeat_left != '0)
                            n.repeat_left = n.repeat_left - 1'b1;
                        else
                            n.byte_offset = tbps_pkg::bump_offset(n.byte_offset);
                    end
                end
                if (!stop)
                    n.countdown = n.pulse_length;
            end
        end
    end

    assign nxt                = n;
    assign result.tape_signal = n.signal_level;
    assign result.edge_res    = toggled;
    assign result.next_offset = n.byte_offset;
    assign result.tape_ended  = n.ended_flag;

endmodule

// ===== design/tape_byte_pulse_serializer_unit.sv =====
// tape_byte_pulse_serializer_unit: top level of the tape pulse serializer
// depends on tbps_pkg and tbps_step
//
// plays a byte tape image as a cassette square wave, one tick beat in, one result
// beat out. a tick beat carries elapsed cycles, motor level, a rewind strobe and the
// byte at the offset given by the previous result. the result gives the signal
// level, whether it toggled, the offset to fetch next and the end flag. a tick is
// taken every clock unless the input stalls: the beat lands in an input register,
// the playback state and the result are worked out in one pass of logic and
// written to the state and result registers together, so throughput is one beat
// per cycle while nothing stalls. the input and result registers decouple the
// two sides, so a new tick can be taken while a result waits; the input stalls
// only when both registers are full and the result is held. the config port is
// always ready; write only while no tick is in flight.
module tape_byte_pulse_serializer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // tick beats
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tbps_pkg::in_beat_t                  in_data,
    // result beats
    output logic                                out_valid,
    input  logic                                out_ready,
    output tbps_pkg::out_beat_t                 out_data,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tbps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // input stage
    logic                  item_valid_reg;
    tbps_pkg::in_beat_t    item_reg;
    // result stage
    logic                  out_valid_reg;
    tbps_pkg::out_beat_t   out_reg;
    // playback state and config
    tbps_pkg::play_state_t state_reg;
    tbps_pkg::play_state_t state_next;
    tbps_pkg::cfg_t        cfg_reg;
    tbps_pkg::out_beat_t   result_next;

    logic advance;   // result stage can take a new beat
    logic fire;      // input stage beat is processed this cycle

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = item_valid_reg && advance;
    assign in_ready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    tbps_step u_step (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .nxt    (state_next),
        .result (result_next)
    );

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= tbps_pkg::STATE_RESET;
            cfg_reg        <= tbps_pkg::CFG_RESET;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= item_valid_reg;
            if (fire)
                state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tbps_pkg::CFG_TAPE_LENGTH:
                        cfg_reg.tape_length <= cfg_data[tbps_pkg::LEN_BITS-1:0];
                    tbps_pkg::CFG_ONE_PULSE:
                        cfg_reg.one_pulse_cycles <= cfg_data[tbps_pkg::PULSE_BITS-1:0];
                    tbps_pkg::CFG_ZERO_PULSE:
                        cfg_reg.zero_pulse_cycles <= cfg_data[tbps_pkg::PULSE_BITS-1:0];
                    default:
                        ;   // unused index, write ignored
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_data;
        if (fire)
            out_reg <= result_next;
    end

    // sync repeat counter never reloads above its start value
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.repeat_left <= tbps_pkg::SYNC_REPEATS)
        else $error("repeat counter out of range");

    // frame slots only advance with the motor running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.frame_slot != '0) |-> state_reg.motor_on)
        else $error("frame slot moved with motor off");

    // input stalls only when both stages are full and the result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without back pressure");

    // a processed tick always shows up as a result beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed tick lost");

endmodule
